/* sv/tod_pkg.sv */
// ----------------------------------------------------------------------------
// tod_pkg
// Shared types, constants and helper functions of the time-of-day clock.
// ----------------------------------------------------------------------------
`default_nettype none

package tod_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned DebW   = 8;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned FrameW = 32;
  localparam int unsigned SegW   = 7;
  localparam int unsigned DigitW = 4;

  localparam logic [TickW-1:0] TicksPerSecondReset = 16'd32768;
  localparam logic [DebW-1:0]  DebounceTargetReset = 8'd8;

  localparam logic [SecW-1:0]  SecLast  = 6'd59;
  localparam logic [MinW-1:0]  MinLast  = 6'd59;
  localparam logic [HourW-1:0] HourLast = 5'd23;

  localparam int unsigned SampleGateBit = 8;

  localparam logic [CodeW-1:0] ThrHourDown = 8'd204;
  localparam logic [CodeW-1:0] ThrMinUp    = 8'd153;
  localparam logic [CodeW-1:0] ThrHourUp   = 8'd102;
  localparam logic [CodeW-1:0] ThrMinDown  = 8'd51;

  localparam logic OpTick   = 1'b0;
  localparam logic OpSample = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgTicksPerSecond = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounceTarget = 1'd1;

  typedef enum logic [2:0] {
    BTN_IDLE      = 3'd0,
    BTN_HOUR_UP   = 3'd1,
    BTN_HOUR_DOWN = 3'd2,
    BTN_MIN_UP    = 3'd3,
    BTN_MIN_DOWN  = 3'd4
  } btn_e;

  function automatic btn_e classify(input logic [CodeW-1:0] code);
    btn_e btn;
    if (code > ThrHourDown) begin
      btn = BTN_HOUR_DOWN;
    end else if (code > ThrMinUp) begin
      btn = BTN_MIN_UP;
    end else if (code > ThrHourUp) begin
      btn = BTN_HOUR_UP;
    end else if (code > ThrMinDown) begin
      btn = BTN_MIN_DOWN;
    end else begin
      btn = BTN_IDLE;
    end
    return btn;
  endfunction

  // tens digit of a value below 60
  function automatic logic [DigitW-1:0] tens_of(input logic [MinW-1:0] v);
    logic [DigitW-1:0] t;
    if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0:    s = 7'b1111110;
      4'd1:    s = 7'b0110000;
      4'd2:    s = 7'b1101101;
      4'd3:    s = 7'b1111001;
      4'd4:    s = 7'b0110011;
      4'd5:    s = 7'b1011011;
      4'd6:    s = 7'b1011111;
      4'd7:    s = 7'b1110000;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1111011;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/tod_intf.sv */
// ----------------------------------------------------------------------------
// tod_intf
// Valid/ready channel interfaces of the time-of-day clock.
// ----------------------------------------------------------------------------
`default_nettype none

interface tod_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [tod_pkg::CodeW-1:0]   adc_code;

  modport source (output valid, output operation, output adc_code, input ready);
  modport sink   (input valid, input operation, input adc_code, output ready);
endinterface

interface tod_out_if;
  logic                        valid;
  logic                        ready;
  logic [tod_pkg::HourW-1:0]   hours;
  logic [tod_pkg::MinW-1:0]    minutes;
  logic [tod_pkg::SecW-1:0]    seconds;
  logic [2:0]                  action_taken;
  logic                        display_update;
  logic [tod_pkg::FrameW-1:0]  display_frame;

  modport source (output valid, output hours, output minutes, output seconds,
                  output action_taken, output display_update, output display_frame,
                  input ready);
  modport sink   (input valid, input hours, input minutes, input seconds,
                  input action_taken, input display_update, input display_frame,
                  output ready);
endinterface

interface tod_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tod_pkg::CfgIdxW-1:0]   index;
  logic [tod_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/tod_seg_frame.sv */
// ----------------------------------------------------------------------------
// tod_seg_frame
// Builds the 32-bit seven-segment shift frame from the displayed time.
// ----------------------------------------------------------------------------
`default_nettype none

module tod_seg_frame (
  input  wire logic [tod_pkg::HourW-1:0]  hours_i,
  input  wire logic [tod_pkg::MinW-1:0]   minutes_i,
  input  wire logic                       sec_lsb_i,
  input  wire logic                       update_i,
  output logic      [tod_pkg::FrameW-1:0] frame_o
);

  logic [tod_pkg::MinW-1:0]   hours_ext;
  logic [tod_pkg::DigitW-1:0] hour_tens;
  logic [tod_pkg::DigitW-1:0] hour_ones;
  logic [tod_pkg::DigitW-1:0] min_tens;
  logic [tod_pkg::DigitW-1:0] min_ones;
  logic [tod_pkg::MinW-1:0]   hour_tens_x10;
  logic [tod_pkg::MinW-1:0]   min_tens_x10;

  assign hours_ext     = {1'b0, hours_i};
  assign hour_tens     = tod_pkg::tens_of(hours_ext);
  assign min_tens      = tod_pkg::tens_of(minutes_i);
  assign hour_tens_x10 = tod_pkg::MinW'(hour_tens) * 6'd10;
  assign min_tens_x10  = tod_pkg::MinW'(min_tens) * 6'd10;
  assign hour_ones     = tod_pkg::DigitW'(hours_ext - hour_tens_x10);
  assign min_ones      = tod_pkg::DigitW'(minutes_i - min_tens_x10);

  always_comb begin
    if (update_i) begin
      frame_o = {1'b0, tod_pkg::seg_of(min_ones),
                 1'b0, tod_pkg::seg_of(min_tens),
                 sec_lsb_i, tod_pkg::seg_of(hour_ones),
                 1'b0, tod_pkg::seg_of(hour_tens)};
    end else begin
      frame_o = '0;
    end
  end

endmodule

`default_nettype wire

/* sv/time_of_day_clock_with_button_set.sv */
// ----------------------------------------------------------------------------
// time_of_day_clock_with_button_set
// 24-hour clock driven by tick transactions, set by debounced ladder buttons.
// ----------------------------------------------------------------------------
// Each input transaction (a tick or a button ADC sample) produces one result
// transaction carrying the time after it, the button action that fired and,
// when a refresh was pending, the seven-segment shift frame. The block takes
// one transaction per cycle: the time and debounce registers update on the
// accepting edge and the result is held in a one-deep output register, so a
// new transaction is taken whenever that register is empty or being drained.
// Configuration writes complete in the cycle they are
// presented.
`default_nettype none

module time_of_day_clock_with_button_set (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tod_in_if.sink     in_i,
  tod_out_if.source  out_o,
  tod_cfg_if.sink    cfg_i
);

  logic [tod_pkg::TickW-1:0] tps_q;
  logic [tod_pkg::DebW-1:0]  target_q;

  logic [tod_pkg::TickW-1:0] tick_q, tick_d, tick_inc;
  logic [tod_pkg::SecW-1:0]  sec_q, sec_d;
  logic [tod_pkg::MinW-1:0]  min_q, min_d;
  logic [tod_pkg::HourW-1:0] hour_q, hour_d;
  logic                      pend_q, pend_d, pend_now;
  logic [tod_pkg::DebW-1:0]  deb_q, deb_d, deb_inc;
  tod_pkg::btn_e             last_q, last_d, btn;
  logic                      latched_q, latched_d;

  logic                      out_valid_q;
  tod_pkg::btn_e             action_q, action_d;
  logic                      update_q;
  logic                      in_acc;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q    <= tod_pkg::TicksPerSecondReset;
      target_q <= tod_pkg::DebounceTargetReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tod_pkg::CfgTicksPerSecond: tps_q    <= cfg_i.data;
        tod_pkg::CfgDebounceTarget: target_q <= cfg_i.data[tod_pkg::DebW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_d    = tick_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    pend_now  = pend_q;
    pend_d    = pend_q;
    deb_d     = deb_q;
    last_d    = last_q;
    latched_d = latched_q;
    action_d  = tod_pkg::BTN_IDLE;
    tick_inc  = tick_q + 16'd1;
    deb_inc   = deb_q + 8'd1;
    btn       = tod_pkg::classify(in_i.adc_code);
    if (in_acc) begin
      if (in_i.operation == tod_pkg::OpTick) begin
        if (tick_inc == tps_q) begin
          tick_d   = '0;
          pend_now = 1'b1;
          if (sec_q >= tod_pkg::SecLast) begin
            sec_d = '0;
            if (min_q >= tod_pkg::MinLast) begin
              min_d  = '0;
              hour_d = (hour_q >= tod_pkg::HourLast) ? '0 : hour_q + 5'd1;
            end else begin
              min_d = min_q + 6'd1;
            end
          end else begin
            sec_d = sec_q + 6'd1;
          end
        end else begin
          tick_d = tick_inc;
        end
      end else if (tick_q[tod_pkg::SampleGateBit]) begin
        if (!latched_q) begin
          if (btn == last_q && btn != tod_pkg::BTN_IDLE) begin
            deb_d = deb_inc;
            if (deb_inc == target_q) begin
              latched_d = 1'b1;
              action_d  = btn;
              pend_now  = 1'b1;
              case (btn)
                tod_pkg::BTN_HOUR_DOWN: if (hour_q != '0) hour_d = hour_q - 5'd1;
                tod_pkg::BTN_HOUR_UP:   if (hour_q < tod_pkg::HourLast) hour_d = hour_q + 5'd1;
                tod_pkg::BTN_MIN_UP:    if (min_q < tod_pkg::MinLast) min_d = min_q + 6'd1;
                tod_pkg::BTN_MIN_DOWN:  if (min_q != '0) min_d = min_q - 6'd1;
                default: ;
              endcase
            end
          end else begin
            if (btn != tod_pkg::BTN_IDLE) last_d = btn;
            deb_d = '0;
          end
        end else if (btn == tod_pkg::BTN_IDLE) begin
          latched_d = 1'b0;
        end
      end
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      sec_q       <= '0;
      min_q       <= '0;
      hour_q      <= '0;
      pend_q      <= 1'b1;
      deb_q       <= '0;
      last_q      <= tod_pkg::BTN_IDLE;
      latched_q   <= 1'b0;
      out_valid_q <= 1'b0;
      action_q    <= tod_pkg::BTN_IDLE;
      update_q    <= 1'b0;
    end else begin
      tick_q    <= tick_d;
      sec_q     <= sec_d;
      min_q     <= min_d;
      hour_q    <= hour_d;
      pend_q    <= pend_d;
      deb_q     <= deb_d;
      last_q    <= last_d;
      latched_q <= latched_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
        action_q    <= action_d;
        update_q    <= pend_now;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // time registers change only on an accepted transaction, so they hold
  // the values of the pending result
  assign out_o.valid          = out_valid_q;
  assign out_o.hours          = hour_q;
  assign out_o.minutes        = min_q;
  assign out_o.seconds        = sec_q;
  assign out_o.action_taken   = action_q;
  assign out_o.display_update = update_q;

  tod_seg_frame u_seg_frame (
    .hours_i   (hour_q),
    .minutes_i (min_q),
    .sec_lsb_i (sec_q[0]),
    .update_i  (update_q),
    .frame_o   (out_o.display_frame)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 24-hour clock with debounced button setting.
// ----------------------------------------------------------------------------
// Sends tick and button-sample transactions through the valid/ready input.
// A behavioral model of the time counters, the sample gate and the debouncer
// predicts each result transaction, and every field is checked at the output.
// The sender works in bursts and the receiver stalls on its own pattern. Both
// registers are rewritten between phases while the block is drained. The
// directed part covers the threshold codes, saturation at both ends of the
// hours and minutes, the minute and hour carries and the midnight wrap.
// Random phases follow.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit    = 200_000;
  localparam int unsigned HoldoffCycles = 300;

  localparam logic [7:0]  NoneTop    = 8'd51;
  localparam logic [7:0]  MinDownTop = 8'd102;
  localparam logic [7:0]  HourUpTop  = 8'd153;
  localparam logic [7:0]  MinUpTop   = 8'd204;
  localparam logic [4:0]  HourMax    = 5'd23;
  localparam logic [5:0]  MinMax     = 6'd59;
  localparam logic [5:0]  SecMax     = 6'd59;
  localparam logic [15:0] ResetTicksPerSecond = 16'd32768;
  localparam logic [7:0]  ResetDebounce       = 8'd8;

  typedef enum int unsigned {SinkOpen, SinkRandom, SinkSparse} sink_mode_e;

  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [2:0]  action;
    logic        update;
    logic [31:0] frame;
  } readout_t;

  logic clk_i;
  logic rst_ni;

  tod_in_if  in_if ();
  tod_out_if out_if ();
  tod_cfg_if cfg_if ();

  time_of_day_clock_with_button_set uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic [15:0]   tps_cfg;
  logic [7:0]    deb_cfg;
  logic [15:0]   tick_q;
  logic [5:0]    sec_q;
  logic [5:0]    min_q;
  logic [4:0]    hour_q;
  logic          refresh_q;
  logic [7:0]    deb_cnt;
  tod_pkg::btn_e last_btn;
  logic          latched;

  readout_t pending_readouts[$];

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned actions_fired;
  int unsigned gated_samples;
  int unsigned second_steps;
  int unsigned day_wraps;
  int unsigned burst_left;
  int unsigned holdoff_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic tod_pkg::btn_e button_of_code(input logic [7:0] code);
    if (code > MinUpTop) return tod_pkg::BTN_HOUR_DOWN;
    if (code > HourUpTop) return tod_pkg::BTN_MIN_UP;
    if (code > MinDownTop) return tod_pkg::BTN_HOUR_UP;
    if (code > NoneTop) return tod_pkg::BTN_MIN_DOWN;
    return tod_pkg::BTN_IDLE;
  endfunction

  function automatic logic [7:0] code_for_button(input tod_pkg::btn_e b);
    case (b)
      tod_pkg::BTN_MIN_DOWN:  return 8'($urandom_range(NoneTop + 1, MinDownTop));
      tod_pkg::BTN_HOUR_UP:   return 8'($urandom_range(MinDownTop + 1, HourUpTop));
      tod_pkg::BTN_MIN_UP:    return 8'($urandom_range(HourUpTop + 1, MinUpTop));
      tod_pkg::BTN_HOUR_DOWN: return 8'($urandom_range(MinUpTop + 1, 255));
      default:                return 8'($urandom_range(0, NoneTop));
    endcase
  endfunction

  function automatic logic [6:0] digit_segments(input int unsigned d);
    case (d)
      0:       return 7'h7E;
      1:       return 7'h30;
      2:       return 7'h6D;
      3:       return 7'h79;
      4:       return 7'h33;
      5:       return 7'h5B;
      6:       return 7'h5F;
      7:       return 7'h70;
      8:       return 7'h7F;
      default: return 7'h7B;
    endcase
  endfunction

  function automatic logic [31:0] frame_of(input logic [4:0] h, input logic [5:0] m,
                                           input logic [5:0] s);
    return {1'b0, digit_segments(m % 10), 1'b0, digit_segments(m / 10), s[0],
            digit_segments(h % 10), 1'b0, digit_segments(h / 10)};
  endfunction

  task automatic apply_button(input tod_pkg::btn_e b);
    refresh_q = 1'b1;
    case (b)
      tod_pkg::BTN_HOUR_UP: begin
        if (hour_q < HourMax) hour_q++;
      end
      tod_pkg::BTN_HOUR_DOWN: begin
        if (hour_q != 0) hour_q--;
      end
      tod_pkg::BTN_MIN_UP: begin
        if (min_q < MinMax) min_q++;
      end
      tod_pkg::BTN_MIN_DOWN: begin
        if (min_q != 0) min_q--;
      end
      default: ;
    endcase
  endtask

  task automatic predict_readout(input logic op, input logic [7:0] code);
    readout_t      r;
    tod_pkg::btn_e b;
    r = '0;
    if (op == tod_pkg::OpTick) begin
      tick_q++;
      if (tick_q == tps_cfg) begin
        tick_q = '0;
        refresh_q = 1'b1;
        second_steps++;
        if (sec_q == SecMax) begin
          sec_q = '0;
          if (min_q == MinMax) begin
            min_q = '0;
            if (hour_q == HourMax) begin
              hour_q = '0;
              day_wraps++;
            end else begin
              hour_q++;
            end
          end else begin
            min_q++;
          end
        end else begin
          sec_q++;
        end
      end
    end else if (!tick_q[8]) begin
      gated_samples++;
    end else begin
      b = button_of_code(code);
      if (!latched) begin
        if (b == last_btn && b != tod_pkg::BTN_IDLE) begin
          deb_cnt++;
          if (deb_cnt == deb_cfg) begin
            apply_button(b);
            latched = 1'b1;
            r.action = b;
            actions_fired++;
          end
        end else begin
          if (b != tod_pkg::BTN_IDLE) last_btn = b;
          deb_cnt = '0;
        end
      end else if (b == tod_pkg::BTN_IDLE) begin
        latched = 1'b0;
      end
    end
    r.hours = hour_q;
    r.minutes = min_q;
    r.seconds = sec_q;
    if (refresh_q) begin
      refresh_q = 1'b0;
      r.update = 1'b1;
      r.frame = frame_of(hour_q, min_q, sec_q);
    end
    pending_readouts.push_back(r);
  endtask

  task automatic drive_transaction(input logic op, input logic [7:0] code);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.adc_code <= code;
    predict_readout(op, code);
    items_sent++;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_tick();
    drive_transaction(tod_pkg::OpTick, 8'($urandom));
  endtask

  task automatic send_sample(input logic [7:0] code);
    drive_transaction(tod_pkg::OpSample, code);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_readouts.size() != 0);
  endtask

  task automatic write_registers(input logic [15:0] tps, input logic [7:0] target);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= tod_pkg::CfgTicksPerSecond;
    cfg_if.data <= tps;
    do @(posedge clk_i); while (!cfg_if.ready);
    tps_cfg = tps;
    cfg_if.index <= tod_pkg::CfgDebounceTarget;
    cfg_if.data <= {8'd0, target};
    do @(posedge clk_i); while (!cfg_if.ready);
    deb_cfg = target;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic enter_sample_window();
    while (!tick_q[8]) send_tick();
  endtask

  // release any held press, clear the count, hold the button until it fires
  task automatic press_button(input tod_pkg::btn_e b);
    int unsigned hits;
    enter_sample_window();
    hits = (deb_cfg == 0) ? 256 : deb_cfg;
    if (last_btn != b) hits++;
    while (latched) send_sample(code_for_button(tod_pkg::BTN_IDLE));
    send_sample(code_for_button(tod_pkg::BTN_IDLE));
    repeat (hits) send_sample(code_for_button(b));
    send_sample(code_for_button(tod_pkg::BTN_IDLE));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    readout_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_readouts.size() == 0) begin
        fail_count++;
        $error("result transaction with no expectation pending");
      end else begin
        want = pending_readouts.pop_front();
        check_field("hours", want.hours, out_if.hours);
        check_field("minutes", want.minutes, out_if.minutes);
        check_field("seconds", want.seconds, out_if.seconds);
        check_field("action_taken", want.action, out_if.action_taken);
        check_field("display_update", want.update, out_if.display_update);
        check_field("display_frame", want.frame, out_if.display_frame);
      end
    end
  end

  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    out_if.ready <= 1'b0;
    mode = SinkOpen;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          SinkOpen:   out_if.ready <= 1'b1;
          SinkRandom: out_if.ready <= 1'($urandom_range(0, 1));
          default:    out_if.ready <= (mode_left % 4 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic test_power_up_display();
    send_tick();
    send_sample(8'hFF);
    send_sample(8'h00);
    send_tick();
    drain_results();
  endtask

  task automatic test_button_thresholds();
    logic [7:0] lo;
    write_registers(16'hFFFF, 8'd1);
    enter_sample_window();
    // walk each band from both edges: minute down, hour up, minute up, hour down
    for (int k = 0; k < 4; k++) begin
      lo = 8'(NoneTop + 1 + 51 * k);
      send_sample(lo);
      send_sample(8'(lo + 50));
      send_sample(NoneTop);
      send_sample(8'd0);
    end
    press_button(tod_pkg::BTN_HOUR_DOWN);
    press_button(tod_pkg::BTN_MIN_DOWN);
    drain_results();
  endtask

  task automatic test_output_holdoff();
    tod_pkg::btn_e b;
    write_registers(16'hFFFF, 8'd2);
    holdoff_left = HoldoffCycles;
    repeat (10) begin
      b = tod_pkg::btn_e'($urandom_range(0, 4));
      repeat ($urandom_range(1, 4)) send_sample(code_for_button(b));
      if ($urandom_range(0, 2) == 0) send_tick();
    end
    drain_results();
  endtask

  task automatic test_setting_limits();
    write_registers(16'hFFFF, 8'd1);
    while (hour_q != HourMax) press_button(tod_pkg::BTN_HOUR_UP);
    press_button(tod_pkg::BTN_HOUR_UP);
    while (min_q != MinMax) press_button(tod_pkg::BTN_MIN_UP);
    press_button(tod_pkg::BTN_MIN_UP);
    drain_results();
  endtask

  task automatic test_day_rollover();
    write_registers(tick_q + 16'd1, deb_cfg);
    send_tick();
    drain_results();
    write_registers(16'd1, deb_cfg);
    repeat (60) send_tick();
    drain_results();
  endtask

  task automatic test_random_clock();
    for (int phase = 0; phase < 2; phase++) begin
      write_registers(16'(tick_q + $urandom_range(1, 4)), 8'($urandom_range(1, 255)));
      repeat (15) begin
        if ($urandom_range(0, 4) == 0) send_sample(8'($urandom));
        else send_tick();
      end
      drain_results();
    end
  endtask

  initial begin : stimulus
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.operation <= tod_pkg::OpTick;
    in_if.adc_code <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= tod_pkg::CfgTicksPerSecond;
    cfg_if.data <= '0;
    tps_cfg = ResetTicksPerSecond;
    deb_cfg = ResetDebounce;
    tick_q = '0;
    sec_q = '0;
    min_q = '0;
    hour_q = '0;
    refresh_q = 1'b1;
    deb_cnt = '0;
    last_btn = tod_pkg::BTN_IDLE;
    latched = 1'b0;
    fail_count = 0;
    items_sent = 0;
    actions_fired = 0;
    gated_samples = 0;
    second_steps = 0;
    day_wraps = 0;
    burst_left = 0;
    holdoff_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_power_up_display();
    test_button_thresholds();
    test_output_holdoff();
    test_setting_limits();
    test_day_rollover();
    test_random_clock();

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("%0d transactions in %0d cycles: %0d button actions, %0d samples gated off,",
             items_sent, cycle_count, actions_fired, gated_samples);
    $display("%0d second steps, %0d midnight wraps, hour and minute limits hit both ways.",
             second_steps, day_wraps);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
